/* src/sse_pkg.sv */
`default_nettype none
package sse_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Widths of the fields at the ports.
  localparam int VALUE_PORT_BITS = 16;
  localparam int COUNT_PORT_BITS = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
    val_t key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/sse_cell.sv */
`default_nettype none
module sse_cell (
  input  wire                clk,
  input  wire sse_pkg::cell_ctrl_t ctrl,
  input  wire                occ,
  input  wire sse_pkg::val_t left_val,
  input  wire                left_gek,
  input  wire sse_pkg::val_t right_val,
  output sse_pkg::val_t      val,
  output sse_pkg::val_t      val_next,
  output logic               gek,
  output logic               hit
);
  import sse_pkg::*;

  // An empty cell counts as larger than any key, so gek is a thermometer
  // along the whole chain and its first set bit is the insertion point.
  assign gek = !occ || (val >= ctrl.key);
  assign hit = occ && (val == ctrl.key);

  always_comb begin
    val_next = val;
    if (ctrl.ins) begin
      if (left_gek) begin
        val_next = left_val;
      end else if (gek) begin
        val_next = ctrl.key;
      end
    end else if (ctrl.rem) begin
      if (gek) begin
        val_next = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

/* src/sorted_set_engine.sv */
`default_nettype none
// Sorted set engine: keeps up to 64 distinct 16-bit values in ascending
// order in a chain of cells, one value per cell. Each transfer on the input
// channel inserts, removes or looks up one value, and yields one result
// transfer. All cells compare the value at once and shift towards their
// neighbours in the same cycle, so an item is taken every clock cycle
// unless the input is held off, and its result is written into the
// output register on acceptance. The input is held off only while a
// result waits in that register and the output side is stalling.
module sorted_set_engine (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [1:0]                            op,
  input  wire  [sse_pkg::VALUE_PORT_BITS-1:0]   value,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  was_present,
  output logic [1:0]                            status,
  output logic [sse_pkg::COUNT_PORT_BITS-1:0]   count_after,
  output logic [sse_pkg::VALUE_PORT_BITS-1:0]   smallest,
  output logic                                  is_empty
);
  import sse_pkg::*;

  count_t     count;
  count_t     count_next;
  logic       accept;
  logic       present;
  logic       full;
  logic [1:0] status_next;
  cell_ctrl_t ctrl;

  val_t                cell_val  [CAPACITY];
  val_t                cell_next [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] gek;
  logic [CAPACITY-1:0] hit;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign present  = |hit;
  assign full     = (count == count_t'(CAPACITY));

  always_comb begin
    ctrl.key    = value[VALUE_BITS-1:0];
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    count_next  = count;
    status_next = ST_NOP;
    unique case (op)
      OP_INSERT: begin
        if (present) begin
          status_next = ST_NOP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          ctrl.ins    = accept;
          count_next  = count + count_t'(1);
        end
      end
      OP_REMOVE: begin
        if (present) begin
          status_next = ST_DONE;
          ctrl.rem    = accept;
          count_next  = count - count_t'(1);
        end
      end
      OP_LOOKUP: status_next = ST_DONE;
      default:   status_next = ST_NOP;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic left_gek;
    val_t left_val;
    val_t right_val;

    assign occ[i] = (count_t'(i) < count);

    if (i == 0) begin : g_first
      assign left_gek = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign left_gek = gek[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_body
      assign right_val = cell_val[i+1];
    end

    sse_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .left_val  (left_val),
      .left_gek  (left_gek),
      .right_val (right_val),
      .val       (cell_val[i]),
      .val_next  (cell_next[i]),
      .gek       (gek[i]),
      .hit       (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload only changes on a new transfer, so a stalled result holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      was_present <= present;
      status      <= status_next;
      count_after <= COUNT_PORT_BITS'(count_next);
      is_empty    <= (count_next == '0);
      if (count_next == '0) begin
        smallest <= '0;
      end else begin
        smallest <= VALUE_PORT_BITS'(cell_next[0]);
      end
    end
  end

endmodule
`default_nettype wire

/* src/sse_checker.sv */
`default_nettype none
module sse_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 in_valid,
  input wire                                 in_stall,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire [1:0]                           status,
  input wire [sse_pkg::COUNT_PORT_BITS-1:0]  count_after,
  input wire [sse_pkg::VALUE_PORT_BITS-1:0]  smallest,
  input wire                                 is_empty
);
  import sse_pkg::*;

  // Every accepted input produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(count_after) && $stable(status))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count_after == '0)))
    else $error("empty flag disagrees with count");

  a_empty_smallest: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> smallest == '0)
    else $error("smallest not zero on empty set");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count_after == COUNT_PORT_BITS'(CAPACITY))
    else $error("store full reported below capacity");

endmodule

bind sorted_set_engine sse_checker u_sse_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .count_after (count_after),
  .smallest    (smallest),
  .is_empty    (is_empty)
);
`default_nettype wire
